FILE: design/msd_pkg.sv
// Shared types, widths and codes of the mid/side stereo decision block.
package msd_pkg;

  localparam int COEF_BITS   = 24;
  localparam int ENERGY_BITS = 24;
  localparam int PROD_W      = 2 * ENERGY_BITS;
  localparam int ACC_W       = 4 * ENERGY_BITS;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic MODE_BAND = 1'b0;
  localparam logic MODE_COEF = 1'b1;
  localparam logic KIND_BAND = 1'b0;
  localparam logic KIND_COEF = 1'b1;

  localparam logic [1:0] FM_NONE = 2'd0;
  localparam logic [1:0] FM_SOME = 2'd1;
  localparam logic [1:0] FM_ALL  = 2'd2;

  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_A    = 3'd0;
  localparam logic [STEP_W-1:0] STEP_B    = 3'd1;
  localparam logic [STEP_W-1:0] STEP_PP0  = 3'd2;
  localparam logic [STEP_W-1:0] STEP_PP1  = 3'd3;
  localparam logic [STEP_W-1:0] STEP_PP2  = 3'd4;
  localparam logic [STEP_W-1:0] STEP_PP3  = 3'd5;
  localparam logic [STEP_W-1:0] STEP_LAST = 3'd6;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_CMP
  } back_state_e;

  typedef struct packed {
    logic                          is_coef;
    logic                          last_band;
    logic [ENERGY_BITS-1:0]        el;
    logic [ENERGY_BITS-1:0]        er;
    logic [ENERGY_BITS-1:0]        em;
    logic [ENERGY_BITS-1:0]        es;
    logic [ENERGY_BITS-1:0]        tl;
    logic [ENERGY_BITS-1:0]        tr;
    logic [ENERGY_BITS-1:0]        sl;
    logic [ENERGY_BITS-1:0]        sr;
    logic [ENERGY_BITS-1:0]        t;
    logic [ENERGY_BITS-1:0]        dl;
    logic [ENERGY_BITS-1:0]        dr;
    logic [ENERGY_BITS-1:0]        dm;
    logic [ENERGY_BITS-1:0]        ds;
    logic [ENERGY_BITS-1:0]        sp;
    logic                          nz;
    logic signed [COEF_BITS-1:0]   coef_l;
    logic signed [COEF_BITS-1:0]   coef_r;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_link_t;

  typedef struct packed {
    logic                          kind;
    logic                          band_ms;
    logic [ENERGY_BITS-1:0]        thr_l;
    logic [ENERGY_BITS-1:0]        thr_r;
    logic [ENERGY_BITS-1:0]        en_l;
    logic [ENERGY_BITS-1:0]        en_r;
    logic [ENERGY_BITS-1:0]        sp_l;
    logic [ENERGY_BITS-1:0]        sp_r;
    logic signed [COEF_BITS-1:0]   coef_first;
    logic signed [COEF_BITS-1:0]   coef_second;
    logic [1:0]                    frame_mode;
    logic                          frame_done;
  } res_t;

endpackage

FILE: design/mid_side_stereo_decision.sv
// Top level of the per-band mid/side stereo decision block.
// Both transaction kinds pass a 2-entry queue between front and back; the band
// sequencer reuses one 24x24 multiplier per side over 7 steps.
// Throughput: one coefficient transaction per cycle while the back end is idle and its
// output is free; a band transaction holds the back end until its result is loaded.
// Reset: asynchronous and active low; it empties the queues and clears the frame flags.
module mid_side_stereo_decision (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push,
  output logic                               full,
  output logic                               empty,
  input  logic                               pop,
  input  logic                               mode_i,
  input  logic                               last_band_i,
  input  logic [msd_pkg::ENERGY_BITS-1:0]    energy_left_i,
  input  logic [msd_pkg::ENERGY_BITS-1:0]    energy_right_i,
  input  logic [msd_pkg::ENERGY_BITS-1:0]    energy_mid_i,
  input  logic [msd_pkg::ENERGY_BITS-1:0]    energy_side_i,
  input  logic [msd_pkg::ENERGY_BITS-1:0]    thr_left_i,
  input  logic [msd_pkg::ENERGY_BITS-1:0]    thr_right_i,
  input  logic [msd_pkg::ENERGY_BITS-1:0]    spread_left_i,
  input  logic [msd_pkg::ENERGY_BITS-1:0]    spread_right_i,
  input  logic signed [msd_pkg::COEF_BITS-1:0] coef_left_i,
  input  logic signed [msd_pkg::COEF_BITS-1:0] coef_right_i,
  output logic                               kind_o,
  output logic                               band_ms_o,
  output logic [msd_pkg::ENERGY_BITS-1:0]    thr_left_out_o,
  output logic [msd_pkg::ENERGY_BITS-1:0]    thr_right_out_o,
  output logic [msd_pkg::ENERGY_BITS-1:0]    energy_left_out_o,
  output logic [msd_pkg::ENERGY_BITS-1:0]    energy_right_out_o,
  output logic [msd_pkg::ENERGY_BITS-1:0]    spread_left_out_o,
  output logic [msd_pkg::ENERGY_BITS-1:0]    spread_right_out_o,
  output logic signed [msd_pkg::COEF_BITS-1:0] coef_first_out_o,
  output logic signed [msd_pkg::COEF_BITS-1:0] coef_second_out_o,
  output logic [1:0]                         frame_mode_o,
  output logic                               frame_done_o
);
  import msd_pkg::*;

  q_link_t link;
  logic    q_pop;
  logic    res_valid;
  res_t    res;

  msd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_o         (full),
    .mode_i         (mode_i),
    .last_band_i    (last_band_i),
    .energy_left_i  (energy_left_i),
    .energy_right_i (energy_right_i),
    .energy_mid_i   (energy_mid_i),
    .energy_side_i  (energy_side_i),
    .thr_left_i     (thr_left_i),
    .thr_right_i    (thr_right_i),
    .spread_left_i  (spread_left_i),
    .spread_right_i (spread_right_i),
    .coef_left_i    (coef_left_i),
    .coef_right_i   (coef_right_i),
    .q_pop_i        (q_pop),
    .link_o         (link)
  );

  msd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .link_i      (link),
    .q_pop_o     (q_pop),
    .pop_i       (pop),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign empty              = !res_valid;
  assign kind_o             = res.kind;
  assign band_ms_o          = res.band_ms;
  assign thr_left_out_o     = res.thr_l;
  assign thr_right_out_o    = res.thr_r;
  assign energy_left_out_o  = res.en_l;
  assign energy_right_out_o = res.en_r;
  assign spread_left_out_o  = res.sp_l;
  assign spread_right_out_o = res.sp_r;
  assign coef_first_out_o   = res.coef_first;
  assign coef_second_out_o  = res.coef_second;
  assign frame_mode_o       = res.frame_mode;
  assign frame_done_o       = res.frame_done;

`ifndef SYNTHESIS
  a_coef_no_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o == KIND_COEF) |-> (!frame_done_o && frame_mode_o == FM_NONE))
    else $error("coefficient result carries frame status");

  a_ms_thr_equal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o == KIND_BAND && band_ms_o) |->
    (thr_left_out_o == thr_right_out_o && spread_left_out_o == spread_right_out_o))
    else $error("mid/side band has unequal thresholds or spreads");

  a_pop_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> link.valid)
    else $error("back end pops an empty queue");

  a_frame_mode_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && frame_done_o) |-> (frame_mode_o == FM_SOME || frame_mode_o == FM_ALL ||
    (frame_mode_o == FM_NONE && !band_ms_o)))
    else $error("frame mode disagrees with the last band");
`endif

endmodule

FILE: design/msd_front.sv
// Front end: accepts items, precomputes band bounds and queues them for the back end.
module msd_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push_i,
  output logic                               full_o,
  input  logic                               mode_i,
  input  logic                               last_band_i,
  input  logic [msd_pkg::ENERGY_BITS-1:0]    energy_left_i,
  input  logic [msd_pkg::ENERGY_BITS-1:0]    energy_right_i,
  input  logic [msd_pkg::ENERGY_BITS-1:0]    energy_mid_i,
  input  logic [msd_pkg::ENERGY_BITS-1:0]    energy_side_i,
  input  logic [msd_pkg::ENERGY_BITS-1:0]    thr_left_i,
  input  logic [msd_pkg::ENERGY_BITS-1:0]    thr_right_i,
  input  logic [msd_pkg::ENERGY_BITS-1:0]    spread_left_i,
  input  logic [msd_pkg::ENERGY_BITS-1:0]    spread_right_i,
  input  logic signed [msd_pkg::COEF_BITS-1:0] coef_left_i,
  input  logic signed [msd_pkg::COEF_BITS-1:0] coef_right_i,
  input  logic                               q_pop_i,
  output msd_pkg::q_link_t                   link_o
);
  import msd_pkg::*;

  item_t                  mem_q [QUEUE_DEPTH];
  item_t                  item_d;
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CNT_W-1:0] cnt_q, cnt_d;
  logic                   wr_en, rd_en;
  logic [ENERGY_BITS-1:0] t, sp_min;

  always_comb begin
    t      = (thr_left_i < thr_right_i) ? thr_left_i : thr_right_i;
    sp_min = (spread_left_i < spread_right_i) ? spread_left_i : spread_right_i;
    item_d.is_coef   = (mode_i == MODE_COEF);
    item_d.last_band = last_band_i;
    item_d.el        = energy_left_i;
    item_d.er        = energy_right_i;
    item_d.em        = energy_mid_i;
    item_d.es        = energy_side_i;
    item_d.tl        = thr_left_i;
    item_d.tr        = thr_right_i;
    item_d.sl        = spread_left_i;
    item_d.sr        = spread_right_i;
    item_d.t         = t;
    item_d.dl        = (energy_left_i > thr_left_i) ? energy_left_i : thr_left_i;
    item_d.dr        = (energy_right_i > thr_right_i) ? energy_right_i : thr_right_i;
    item_d.dm        = (energy_mid_i > t) ? energy_mid_i : t;
    item_d.ds        = (energy_side_i > t) ? energy_side_i : t;
    item_d.sp        = sp_min >> 1;
    item_d.nz        = (item_d.dl != '0) && (item_d.dr != '0) &&
                       (item_d.dm != '0) && (item_d.ds != '0);
    item_d.coef_l    = coef_left_i;
    item_d.coef_r    = coef_right_i;
  end

  assign full_o = (cnt_q == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign wr_en  = push_i && !full_o;
  assign rd_en  = q_pop_i && (cnt_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!wr_en && rd_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= item_d;
    end
  end

  assign link_o.valid = (cnt_q != '0);
  assign link_o.item  = mem_q[rd_ptr_q];

endmodule

FILE: design/msd_back.sv
// Back end: runs the band decision sequencer, transforms coefficients and holds the result.
module msd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  msd_pkg::q_link_t  link_i,
  output logic              q_pop_o,
  input  logic              pop_i,
  output logic              res_valid_o,
  output msd_pkg::res_t     res_o
);
  import msd_pkg::*;

  back_state_e            state_q, state_d;
  logic [STEP_W-1:0]      step_q, step_d;
  item_t                  work_q;
  logic [PROD_W-1:0]      a_l_q, a_r_q, b_l_q, b_r_q, pp_l_q, pp_r_q;
  logic [ACC_W-1:0]       acc_l_q, acc_r_q;
  logic [ENERGY_BITS-1:0] ml_x, ml_y, mr_x, mr_y;
  logic [PROD_W-1:0]      prod_l, prod_r;
  logic [ACC_W-1:0]       add_l, add_r;
  logic                   out_free, res_load, take_coef, take_band, band_done, use_ms;
  logic                   cur_ms_q, seen_ms_q, seen_lr_q;
  logic                   seen_ms_n, seen_lr_n;
  logic signed [COEF_BITS:0] sum, diff;
  res_t                   res_d, out_q;
  logic                   out_valid_q;

  assign out_free = !out_valid_q || pop_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (link_i.valid && !link_i.item.is_coef) begin
          state_d = BK_MUL;
        end
      end
      BK_MUL: begin
        if (step_q == STEP_LAST) begin
          state_d = BK_CMP;
        end
      end
      BK_CMP: begin
        if (out_free) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    take_coef = 1'b0;
    take_band = 1'b0;
    band_done = 1'b0;
    case (state_q)
      BK_IDLE: begin
        take_coef = link_i.valid && link_i.item.is_coef && out_free;
        take_band = link_i.valid && !link_i.item.is_coef;
      end
      BK_CMP: begin
        band_done = out_free;
      end
      default: begin
      end
    endcase
    q_pop_o  = take_coef || take_band;
    res_load = take_coef || band_done;
  end

  always_comb begin
    step_d = step_q;
    if (take_band) begin
      step_d = STEP_A;
    end else if (state_q == BK_MUL) begin
      step_d = step_q + 1'b1;
    end
  end

  always_comb begin
    ml_x = '0;
    ml_y = '0;
    mr_x = '0;
    mr_y = '0;
    case (step_q)
      STEP_A: begin
        ml_x = work_q.t;
        ml_y = work_q.t;
        mr_x = work_q.tl;
        mr_y = work_q.tr;
      end
      STEP_B: begin
        ml_x = work_q.dl;
        ml_y = work_q.dr;
        mr_x = work_q.dm;
        mr_y = work_q.ds;
      end
      STEP_PP0: begin
        ml_x = a_l_q[ENERGY_BITS-1:0];
        ml_y = b_l_q[ENERGY_BITS-1:0];
        mr_x = a_r_q[ENERGY_BITS-1:0];
        mr_y = b_r_q[ENERGY_BITS-1:0];
      end
      STEP_PP1: begin
        ml_x = a_l_q[ENERGY_BITS-1:0];
        ml_y = b_l_q[PROD_W-1:ENERGY_BITS];
        mr_x = a_r_q[ENERGY_BITS-1:0];
        mr_y = b_r_q[PROD_W-1:ENERGY_BITS];
      end
      STEP_PP2: begin
        ml_x = a_l_q[PROD_W-1:ENERGY_BITS];
        ml_y = b_l_q[ENERGY_BITS-1:0];
        mr_x = a_r_q[PROD_W-1:ENERGY_BITS];
        mr_y = b_r_q[ENERGY_BITS-1:0];
      end
      STEP_PP3: begin
        ml_x = a_l_q[PROD_W-1:ENERGY_BITS];
        ml_y = b_l_q[PROD_W-1:ENERGY_BITS];
        mr_x = a_r_q[PROD_W-1:ENERGY_BITS];
        mr_y = b_r_q[PROD_W-1:ENERGY_BITS];
      end
      default: begin
      end
    endcase
    prod_l = PROD_W'(ml_x) * PROD_W'(ml_y);
    prod_r = PROD_W'(mr_x) * PROD_W'(mr_y);
  end

  always_comb begin
    add_l = '0;
    add_r = '0;
    case (step_q)
      STEP_PP1: begin
        add_l = ACC_W'(pp_l_q);
        add_r = ACC_W'(pp_r_q);
      end
      STEP_PP2, STEP_PP3: begin
        add_l = ACC_W'(pp_l_q) << ENERGY_BITS;
        add_r = ACC_W'(pp_r_q) << ENERGY_BITS;
      end
      STEP_LAST: begin
        add_l = ACC_W'(pp_l_q) << PROD_W;
        add_r = ACC_W'(pp_r_q) << PROD_W;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (take_band) begin
      work_q <= link_i.item;
    end
    if (state_q == BK_MUL) begin
      case (step_q)
        STEP_A: begin
          a_l_q   <= prod_l;
          a_r_q   <= prod_r;
          acc_l_q <= '0;
          acc_r_q <= '0;
        end
        STEP_B: begin
          b_l_q <= prod_l;
          b_r_q <= prod_r;
        end
        default: begin
          pp_l_q  <= prod_l;
          pp_r_q  <= prod_r;
          acc_l_q <= acc_l_q + add_l;
          acc_r_q <= acc_r_q + add_r;
        end
      endcase
    end
  end

  assign use_ms    = work_q.nz && (acc_l_q >= acc_r_q);
  assign seen_ms_n = seen_ms_q || use_ms;
  assign seen_lr_n = seen_lr_q || !use_ms;
  assign sum       = (COEF_BITS + 1)'(link_i.item.coef_l) + (COEF_BITS + 1)'(link_i.item.coef_r);
  assign diff      = (COEF_BITS + 1)'(link_i.item.coef_l) - (COEF_BITS + 1)'(link_i.item.coef_r);

  always_comb begin
    res_d = '0;
    if (state_q == BK_IDLE) begin
      res_d.kind    = KIND_COEF;
      res_d.band_ms = cur_ms_q;
      if (cur_ms_q) begin
        res_d.coef_first  = sum[COEF_BITS:1];
        res_d.coef_second = diff[COEF_BITS:1];
      end else begin
        res_d.coef_first  = link_i.item.coef_l;
        res_d.coef_second = link_i.item.coef_r;
      end
    end else begin
      res_d.kind    = KIND_BAND;
      res_d.band_ms = use_ms;
      if (use_ms) begin
        res_d.thr_l = work_q.t;
        res_d.thr_r = work_q.t;
        res_d.en_l  = work_q.em;
        res_d.en_r  = work_q.es;
        res_d.sp_l  = work_q.sp;
        res_d.sp_r  = work_q.sp;
      end else begin
        res_d.thr_l = work_q.tl;
        res_d.thr_r = work_q.tr;
        res_d.en_l  = work_q.el;
        res_d.en_r  = work_q.er;
        res_d.sp_l  = work_q.sl;
        res_d.sp_r  = work_q.sr;
      end
      if (work_q.last_band) begin
        res_d.frame_done = 1'b1;
        if (!seen_ms_n) begin
          res_d.frame_mode = FM_NONE;
        end else if (seen_lr_n) begin
          res_d.frame_mode = FM_SOME;
        end else begin
          res_d.frame_mode = FM_ALL;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      step_q      <= STEP_A;
      out_valid_q <= 1'b0;
      cur_ms_q    <= 1'b0;
      seen_ms_q   <= 1'b0;
      seen_lr_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= res_load || (out_valid_q && !pop_i);
      if (band_done) begin
        cur_ms_q  <= use_ms;
        seen_ms_q <= work_q.last_band ? 1'b0 : seen_ms_n;
        seen_lr_q <= work_q.last_band ? 1'b0 : seen_lr_n;
      end
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the mid/side stereo band decision block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import msd_pkg::*;

  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 3000;
  localparam int RANDOM_ITEMS = 1300;
  localparam int CALM_FROM    = 3000;
  localparam int CALM_TO      = 4500;
  localparam logic [ENERGY_BITS-1:0] E_MAX = {ENERGY_BITS{1'b1}};
  localparam logic signed [COEF_BITS-1:0] C_MAX = {1'b0, {(COEF_BITS-1){1'b1}}};
  localparam logic signed [COEF_BITS-1:0] C_MIN = {1'b1, {(COEF_BITS-1){1'b0}}};

  typedef struct {
    logic                        mode;
    logic                        last_band;
    logic [ENERGY_BITS-1:0]      e_l, e_r, e_m, e_s;
    logic [ENERGY_BITS-1:0]      t_l, t_r, s_l, s_r;
    logic signed [COEF_BITS-1:0] c_l, c_r;
    bit                          drain;
  } stereo_item_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic push   = 1'b0;
  logic pop    = 1'b0;
  logic full, empty;
  logic                        mode_i = MODE_BAND, last_band_i = 1'b0;
  logic [ENERGY_BITS-1:0]      energy_left_i = '0, energy_right_i = '0;
  logic [ENERGY_BITS-1:0]      energy_mid_i = '0, energy_side_i = '0;
  logic [ENERGY_BITS-1:0]      thr_left_i = '0, thr_right_i = '0;
  logic [ENERGY_BITS-1:0]      spread_left_i = '0, spread_right_i = '0;
  logic signed [COEF_BITS-1:0] coef_left_i = '0, coef_right_i = '0;
  logic                        kind_o, band_ms_o, frame_done_o;
  logic [ENERGY_BITS-1:0]      thr_left_out_o, thr_right_out_o;
  logic [ENERGY_BITS-1:0]      energy_left_out_o, energy_right_out_o;
  logic [ENERGY_BITS-1:0]      spread_left_out_o, spread_right_out_o;
  logic signed [COEF_BITS-1:0] coef_first_out_o, coef_second_out_o;
  logic [1:0]                  frame_mode_o;

  mid_side_stereo_decision u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .push               (push),
    .full               (full),
    .empty              (empty),
    .pop                (pop),
    .mode_i             (mode_i),
    .last_band_i        (last_band_i),
    .energy_left_i      (energy_left_i),
    .energy_right_i     (energy_right_i),
    .energy_mid_i       (energy_mid_i),
    .energy_side_i      (energy_side_i),
    .thr_left_i         (thr_left_i),
    .thr_right_i        (thr_right_i),
    .spread_left_i      (spread_left_i),
    .spread_right_i     (spread_right_i),
    .coef_left_i        (coef_left_i),
    .coef_right_i       (coef_right_i),
    .kind_o             (kind_o),
    .band_ms_o          (band_ms_o),
    .thr_left_out_o     (thr_left_out_o),
    .thr_right_out_o    (thr_right_out_o),
    .energy_left_out_o  (energy_left_out_o),
    .energy_right_out_o (energy_right_out_o),
    .spread_left_out_o  (spread_left_out_o),
    .spread_right_out_o (spread_right_out_o),
    .coef_first_out_o   (coef_first_out_o),
    .coef_second_out_o  (coef_second_out_o),
    .frame_mode_o       (frame_mode_o),
    .frame_done_o       (frame_done_o)
  );

  stereo_item_t pending_q[$];
  res_t         expected_q[$];
  stereo_item_t offered;
  int           n_accepted = 0;
  int           n_popped   = 0;
  int           n_fail     = 0;
  int           cyc        = 0;
  int           stall_cnt  = 0;
  int           hold_left  = 0;
  bit           hold_done  = 1'b0;
  logic         band_is_ms = 1'b0;
  logic         frame_has_ms = 1'b0;
  logic         frame_has_lr = 1'b0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic res_t predict_stereo(stereo_item_t it);
    res_t r;
    logic [ENERGY_BITS-1:0] t, dl, dr, dm, ds, sp;
    logic [4*ENERGY_BITS-1:0] w_t, w_dl, w_dr, w_dm, w_ds, w_tl, w_tr, lhs, rhs;
    logic signed [COEF_BITS:0] wl, wr, sum, dif;
    logic use_ms;
    r = '0;
    if (it.mode == MODE_BAND) begin
      t  = (it.t_l < it.t_r) ? it.t_l : it.t_r;
      dl = (it.e_l > it.t_l) ? it.e_l : it.t_l;
      dr = (it.e_r > it.t_r) ? it.e_r : it.t_r;
      dm = (it.e_m > t) ? it.e_m : t;
      ds = (it.e_s > t) ? it.e_s : t;
      w_t  = (4*ENERGY_BITS)'(t);
      w_dl = (4*ENERGY_BITS)'(dl);
      w_dr = (4*ENERGY_BITS)'(dr);
      w_dm = (4*ENERGY_BITS)'(dm);
      w_ds = (4*ENERGY_BITS)'(ds);
      w_tl = (4*ENERGY_BITS)'(it.t_l);
      w_tr = (4*ENERGY_BITS)'(it.t_r);
      lhs = w_t * w_t * w_dl * w_dr;
      rhs = w_tl * w_tr * w_dm * w_ds;
      use_ms = (dl != 0) && (dr != 0) && (dm != 0) && (ds != 0) && (lhs >= rhs);
      r.kind    = KIND_BAND;
      r.band_ms = use_ms;
      if (use_ms) begin
        sp = ((it.s_l < it.s_r) ? it.s_l : it.s_r) >> 1;
        r.thr_l = t;      r.thr_r = t;
        r.en_l  = it.e_m; r.en_r  = it.e_s;
        r.sp_l  = sp;     r.sp_r  = sp;
        frame_has_ms = 1'b1;
      end else begin
        r.thr_l = it.t_l; r.thr_r = it.t_r;
        r.en_l  = it.e_l; r.en_r  = it.e_r;
        r.sp_l  = it.s_l; r.sp_r  = it.s_r;
        frame_has_lr = 1'b1;
      end
      band_is_ms = use_ms;
      if (it.last_band) begin
        if (!frame_has_ms) r.frame_mode = FM_NONE;
        else if (frame_has_lr) r.frame_mode = FM_SOME;
        else r.frame_mode = FM_ALL;
        r.frame_done = 1'b1;
        frame_has_ms = 1'b0;
        frame_has_lr = 1'b0;
      end
    end else begin
      r.kind    = KIND_COEF;
      r.band_ms = band_is_ms;
      r.coef_first  = it.c_l;
      r.coef_second = it.c_r;
      if (band_is_ms) begin
        wl  = (COEF_BITS + 1)'(it.c_l);
        wr  = (COEF_BITS + 1)'(it.c_r);
        sum = (wl + wr) >>> 1;
        dif = (wl - wr) >>> 1;
        r.coef_first  = sum[COEF_BITS-1:0];
        r.coef_second = dif[COEF_BITS-1:0];
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    n_fail++;
    if (n_fail <= 40)
      $display("mismatch at result %0d, %s: got %h want %h", n_popped, what, got, want);
  endtask

  task automatic match_field(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  function automatic stereo_item_t band_rec(
      logic [ENERGY_BITS-1:0] el, er, em, es, tl, tr, sl, sr, logic last);
    stereo_item_t it;
    it = '{mode: MODE_BAND, last_band: last, e_l: el, e_r: er, e_m: em, e_s: es,
           t_l: tl, t_r: tr, s_l: sl, s_r: sr, c_l: '0, c_r: '0, drain: 1'b0};
    return it;
  endfunction

  function automatic stereo_item_t coef_rec(
      logic signed [COEF_BITS-1:0] l, r, logic last);
    stereo_item_t it;
    it = '{mode: MODE_COEF, last_band: last, e_l: '0, e_r: '0, e_m: '0, e_s: '0,
           t_l: '0, t_r: '0, s_l: '0, s_r: '0, c_l: l, c_r: r, drain: 1'b0};
    return it;
  endfunction

  function automatic logic [ENERGY_BITS-1:0] rand_energy();
    return ENERGY_BITS'($urandom());
  endfunction

  function automatic logic [ENERGY_BITS-1:0] low_energy();
    return ENERGY_BITS'($urandom_range(0, 15));
  endfunction

  function automatic logic [ENERGY_BITS-1:0] edge_energy();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return E_MAX;
      2: return ENERGY_BITS'(1);
      default: return rand_energy();
    endcase
  endfunction

  function automatic logic signed [COEF_BITS-1:0] rand_coef();
    case ($urandom_range(0, 7))
      0: return C_MAX;
      1: return C_MIN;
      2: return COEF_BITS'($urandom_range(0, 6)) - COEF_BITS'(3);
      default: return COEF_BITS'($urandom());
    endcase
  endfunction

  function automatic stereo_item_t random_band(logic last);
    logic [ENERGY_BITS-1:0] base, tl, tr, em, es;
    int style;
    style = $urandom_range(0, 9);
    if (style <= 3) begin
      // Thresholds close together and mid/side energies near the threshold favor mid/side.
      base = ENERGY_BITS'($urandom_range(1, 1 << 20));
      tl = base;
      tr = base + ENERGY_BITS'($urandom_range(0, 3));
      if ($urandom_range(0, 1)) begin
        tl = tr;
        tr = base;
      end
      em = ENERGY_BITS'($urandom_range(0, 32'(base + (base >> 3))));
      es = ENERGY_BITS'($urandom_range(0, 32'(base + (base >> 3))));
      return band_rec(tl + ENERGY_BITS'($urandom_range(0, 1 << 20)),
                      tr + ENERGY_BITS'($urandom_range(0, 1 << 20)),
                      em, es, tl, tr, rand_energy(), rand_energy(), last);
    end else if (style <= 6) begin
      return band_rec(rand_energy(), rand_energy(), rand_energy(), rand_energy(),
                      rand_energy(), rand_energy(), rand_energy(), rand_energy(), last);
    end else if (style == 7) begin
      return band_rec(low_energy(), low_energy(), low_energy(), low_energy(),
                      low_energy(), low_energy(), low_energy(), low_energy(), last);
    end else begin
      return band_rec(edge_energy(), edge_energy(), edge_energy(), edge_energy(),
                      edge_energy(), edge_energy(), edge_energy(), edge_energy(), last);
    end
  endfunction

  // Driver: presents pending items and predicts each accepted transaction.
  always @(posedge clk_i) begin : drive_proc
    stereo_item_t nxt;
    bit busy;
    bit calm;
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      busy = push;
      calm = (cyc >= CALM_FROM) && (cyc < CALM_TO);
      if (push && !full) begin
        expected_q.push_back(predict_stereo(offered));
        n_accepted++;
        busy = 1'b0;
      end
      if (!busy) begin
        if (pending_q.size() != 0 && (calm || $urandom_range(0, 99) >= 11) &&
            (!pending_q[0].drain || n_accepted == n_popped)) begin
          nxt = pending_q.pop_front();
          offered        <= nxt;
          mode_i         <= nxt.mode;
          last_band_i    <= nxt.last_band;
          energy_left_i  <= nxt.e_l;
          energy_right_i <= nxt.e_r;
          energy_mid_i   <= nxt.e_m;
          energy_side_i  <= nxt.e_s;
          thr_left_i     <= nxt.t_l;
          thr_right_i    <= nxt.t_r;
          spread_left_i  <= nxt.s_l;
          spread_right_i <= nxt.s_r;
          coef_left_i    <= nxt.c_l;
          coef_right_i   <= nxt.c_r;
          push           <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result against the oldest prediction.
  always @(posedge clk_i) begin : mon_proc
    res_t want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result with nothing expected", {31'd0, kind_o}, 32'd0);
        end else begin
          want = expected_q.pop_front();
          match_field("kind", 32'(kind_o), 32'(want.kind));
          match_field("band_ms", 32'(band_ms_o), 32'(want.band_ms));
          match_field("thr_left_out", 32'(thr_left_out_o), 32'(want.thr_l));
          match_field("thr_right_out", 32'(thr_right_out_o), 32'(want.thr_r));
          match_field("energy_left_out", 32'(energy_left_out_o), 32'(want.en_l));
          match_field("energy_right_out", 32'(energy_right_out_o), 32'(want.en_r));
          match_field("spread_left_out", 32'(spread_left_out_o), 32'(want.sp_l));
          match_field("spread_right_out", 32'(spread_right_out_o), 32'(want.sp_r));
          match_field("coef_first_out", 32'(coef_first_out_o), 32'(want.coef_first));
          match_field("coef_second_out", 32'(coef_second_out_o), 32'(want.coef_second));
          match_field("frame_mode", 32'(frame_mode_o), 32'(want.frame_mode));
          match_field("frame_done", 32'(frame_done_o), 32'(want.frame_done));
        end
        n_popped <= n_popped + 1;
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        pop <= 1'b0;
      end else if (!hold_done && n_popped >= HOLD_AT) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        pop <= 1'b0;
      end else begin
        pop <= ((cyc >= CALM_FROM) && (cyc < CALM_TO)) || ($urandom_range(0, 99) >= 11);
      end
    end
  end

  always @(posedge clk_i) begin : watchdog_proc
    cyc <= cyc + 1;
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin : stim_proc
    stereo_item_t tmp;
    int n_directed;
    int nb;
    int nc;
    logic last;
    // Coefficients ahead of any band pass through.
    pending_q.push_back(coef_rec(C_MAX, C_MIN, 1'b0));
    // Zero ratio denominators keep the band left/right.
    pending_q.push_back(band_rec(0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
    pending_q.push_back(band_rec(0, 7, 9, 11, 0, 5, 3, 4, 1'b0));
    // Clear mid/side band with an odd spread to check the floor of the half.
    pending_q.push_back(band_rec(1000, 1000, 10, 10, 100, 100, 7, 9, 1'b0));
    pending_q.push_back(coef_rec(C_MAX, C_MAX, 1'b0));
    pending_q.push_back(coef_rec(C_MIN, C_MIN, 1'b0));
    pending_q.push_back(coef_rec(C_MAX, C_MIN, 1'b0));
    pending_q.push_back(coef_rec(C_MIN, C_MAX, 1'b0));
    pending_q.push_back(coef_rec(-3, 0, 1'b1));
    // Equal products at full scale choose mid/side; the frame has both kinds of band.
    pending_q.push_back(band_rec(E_MAX, E_MAX, E_MAX, E_MAX, E_MAX, E_MAX, E_MAX, E_MAX,
                                 1'b1));
    pending_q.push_back(coef_rec(5, -6, 1'b0));
    pending_q.push_back(band_rec(500, 600, 20, 30, 50, 50, 13, 15, 1'b0));
    pending_q.push_back(band_rec(E_MAX, E_MAX, E_MAX, E_MAX, E_MAX, E_MAX, E_MAX, E_MAX,
                                 1'b1));
    pending_q.push_back(band_rec(1000, 1000, 5000, 5000, 1000, 10, 40, 50, 1'b1));
    pending_q.push_back(coef_rec(-1, 1, 1'b1));
    pending_q.push_back(band_rec(0, 0, 0, 0, E_MAX, E_MAX, 1, E_MAX, 1'b1));
    pending_q.push_back(coef_rec(C_MIN, 1, 1'b0));
    pending_q.push_back(band_rec(3, 5, 4, 6, 0, 5, E_MAX, 2, 1'b1));
    pending_q.push_back(coef_rec(-7, -2, 1'b0));
    n_directed = pending_q.size();

    while (pending_q.size() < n_directed + RANDOM_ITEMS) begin
      if ($urandom_range(0, 19) == 0)
        pending_q.push_back(coef_rec(rand_coef(), rand_coef(), 1'($urandom())));
      nb = $urandom_range(1, 6);
      for (int b = 0; b < nb; b++) begin
        last = (b == nb - 1) && ($urandom_range(0, 9) != 0);
        pending_q.push_back(random_band(last));
        nc = $urandom_range(0, 4);
        for (int c = 0; c < nc; c++)
          pending_q.push_back(coef_rec(rand_coef(), rand_coef(),
                                       $urandom_range(0, 9) == 0));
      end
    end
    tmp = pending_q[n_directed];
    tmp.drain = 1'b1;
    pending_q[n_directed] = tmp;
    tmp = pending_q[n_directed + RANDOM_ITEMS / 2];
    tmp.drain = 1'b1;
    pending_q[n_directed + RANDOM_ITEMS / 2] = tmp;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(negedge clk_i); while (pending_q.size() != 0 || push);
    while (n_popped != n_accepted) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
    if (expected_q.size() != 0)
      report_mismatch("expected results never came", expected_q.size(), 32'd0);
    if (n_fail == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
